### design/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// shared types, codes and character constants of the bracket balance checker
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int LINE_BITS_DEF   = 16;
    localparam int OUT_LINE_BITS   = 16;

    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_DQ     = 3'd1;
    localparam logic [2:0] MODE_SQ     = 3'd2;
    localparam logic [2:0] MODE_LINEC  = 3'd3;
    localparam logic [2:0] MODE_BLOCKC = 3'd4;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_MATCH   = 3'd1;
    localparam logic [2:0] EV_ERROR   = 3'd2;
    localparam logic [2:0] EV_BAL     = 3'd3;
    localparam logic [2:0] EV_UNBAL   = 3'd4;
    localparam logic [2:0] EV_IDLE    = 3'd5;

    localparam logic [1:0] BR_PAREN   = 2'd0;
    localparam logic [1:0] BR_BRACE   = 2'd1;
    localparam logic [1:0] BR_BRACKET = 2'd2;
    localparam logic [1:0] BR_NONE    = 2'd3;

    localparam logic [2:0] KIND_DQ    = 3'd3;
    localparam logic [2:0] KIND_SQ    = 3'd4;
    localparam logic [2:0] KIND_BLOCK = 3'd5;
    localparam logic [2:0] KIND_NONE  = 3'd6;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } char_beat_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [2:0]  symbol_kind;
        logic [15:0] symbol_line;
    } res_beat_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    function automatic logic [1:0] opener_kind(input logic [7:0] ch);
        logic [1:0] k;
        case (ch)
            CH_LPAREN: k = BR_PAREN;
            CH_LBRACE: k = BR_BRACE;
            CH_LBRACK: k = BR_BRACKET;
            default:   k = BR_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] closer_kind(input logic [7:0] ch);
        logic [1:0] k;
        case (ch)
            CH_RPAREN: k = BR_PAREN;
            CH_RBRACE: k = BR_BRACE;
            CH_RBRACK: k = BR_BRACKET;
            default:   k = BR_NONE;
        endcase
        return k;
    endfunction

endpackage

### design/bracket_balance_checker.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker
// scans source text one byte per beat, checks bracket nesting, quotes and
// comments, and gives a verdict on the last byte
// ----------------------------------------------------------------------------
//  channel | signals                           | beat
//  char    | char_valid, char_ready, char_beat | one source byte, last marker
//  res     | res_valid, res_ready, res_beat    | event, symbol kind, line
//
//  one result per byte, one byte per cycle while char_ready is high; the
//  stack top sits in cell 0 of a row of STACK_DEPTH shifting cells; the
//  result is registered and valid in the cycle after its byte; char_ready
//  falls only while a result is held and res_ready is low
//  after reset the block is ready at once; no clearing pass
module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
    parameter int LINE_BITS   = bbc_pkg::LINE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_ready,
    input  bbc_pkg::char_beat_t char_beat,
    output logic                res_valid,
    input  logic                res_ready,
    output bbc_pkg::res_beat_t  res_beat
);

    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int OUT_W_PAD = bbc_pkg::OUT_LINE_BITS;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [2:0]           mode_reg, mode_next;
    logic [7:0]           prev_reg, prev_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] pend_reg, pend_next;
    logic                 err_reg, err_next;
    logic                 res_valid_reg;
    bbc_pkg::res_beat_t   res_reg;

    logic [1:0]           cell_kind [STACK_DEPTH];
    logic [LINE_BITS-1:0] cell_line [STACK_DEPTH];

    bbc_pkg::stack_op_t   op;
    logic [1:0]           push_kind;
    logic                 take;
    logic [7:0]           ch;
    logic [1:0]           ok, ck;
    logic [2:0]           ev, kd, qkind;
    logic [LINE_BITS-1:0] ln, top_line;
    logic [1:0]           top_kind;
    logic [LINE_BITS+OUT_W_PAD-1:0] ln_wide;

    assign char_ready = !res_valid_reg || res_ready;
    assign take       = char_valid && char_ready;
    assign ch         = char_beat.char_code;
    assign ok         = bbc_pkg::opener_kind(ch);
    assign ck         = bbc_pkg::closer_kind(ch);

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            logic [1:0]           up_k, dn_k;
            logic [LINE_BITS-1:0] up_l, dn_l;
            if (gi == 0)
            begin : g_head
                assign up_k = push_kind;
                assign up_l = line_reg;
            end
            else
            begin : g_body
                assign up_k = cell_kind[gi-1];
                assign up_l = cell_line[gi-1];
            end
            if (gi == STACK_DEPTH - 1)
            begin : g_tail
                assign dn_k = cell_kind[gi];
                assign dn_l = cell_line[gi];
            end
            else
            begin : g_link
                assign dn_k = cell_kind[gi+1];
                assign dn_l = cell_line[gi+1];
            end
            bbc_stack_cell #(
                .LINE_BITS (LINE_BITS)
            ) u_cell (
                .clk       (clk),
                .op        (op),
                .up_kind   (up_k),
                .up_line   (up_l),
                .down_kind (dn_k),
                .down_line (dn_l),
                .kind      (cell_kind[gi]),
                .line      (cell_line[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        mode_next  = mode_reg;
        prev_next  = prev_reg;
        line_next  = line_reg;
        pend_next  = pend_reg;
        err_next   = err_reg;
        op         = '0;
        push_kind  = ok;
        ev         = bbc_pkg::EV_NONE;
        kd         = bbc_pkg::KIND_NONE;
        ln         = '0;
        qkind      = (mode_reg == bbc_pkg::MODE_DQ) ? bbc_pkg::KIND_DQ : bbc_pkg::KIND_SQ;
        top_kind   = cell_kind[0];
        top_line   = cell_line[0];

        if (err_reg)
        begin
            ev = bbc_pkg::EV_IDLE;
        end
        else
        begin
            case (mode_reg)
                bbc_pkg::MODE_DQ, bbc_pkg::MODE_SQ:
                begin
                    if (ch == bbc_pkg::CH_NL)
                    begin
                        err_next = 1'b1;
                        ev       = bbc_pkg::EV_ERROR;
                        kd       = qkind;
                        ln       = pend_reg;
                    end
                    else if ((mode_reg == bbc_pkg::MODE_DQ && ch == bbc_pkg::CH_DQUOTE) ||
                             (mode_reg == bbc_pkg::MODE_SQ && ch == bbc_pkg::CH_SQUOTE))
                    begin
                        ev        = bbc_pkg::EV_MATCH;
                        kd        = qkind;
                        ln        = pend_reg;
                        mode_next = bbc_pkg::MODE_NORMAL;
                        prev_next = ch;
                    end
                    else
                    begin
                        prev_next = ch;
                    end
                end
                bbc_pkg::MODE_LINEC:
                begin
                    prev_next = ch;
                    if (ch == bbc_pkg::CH_NL)
                    begin
                        mode_next = bbc_pkg::MODE_NORMAL;
                        if (line_reg != '1)
                            line_next = line_reg + 1'b1;
                    end
                end
                bbc_pkg::MODE_BLOCKC:
                begin
                    prev_next = ch;
                    if (ch == bbc_pkg::CH_NL)
                    begin
                        if (line_reg != '1)
                            line_next = line_reg + 1'b1;
                    end
                    else if (ch == bbc_pkg::CH_SLASH && prev_reg == bbc_pkg::CH_STAR)
                    begin
                        ev        = bbc_pkg::EV_MATCH;
                        kd        = bbc_pkg::KIND_BLOCK;
                        ln        = pend_reg;
                        mode_next = bbc_pkg::MODE_NORMAL;
                        prev_next = 8'd0;
                    end
                end
                default:
                begin
                    mode_next = bbc_pkg::MODE_NORMAL;
                    prev_next = ch;
                    if (ch == bbc_pkg::CH_NL)
                    begin
                        if (line_reg != '1)
                            line_next = line_reg + 1'b1;
                    end
                    else if (ch == bbc_pkg::CH_DQUOTE || ch == bbc_pkg::CH_SQUOTE)
                    begin
                        mode_next = (ch == bbc_pkg::CH_DQUOTE) ? bbc_pkg::MODE_DQ
                                                               : bbc_pkg::MODE_SQ;
                        pend_next = line_reg;
                    end
                    else if (ch == bbc_pkg::CH_SLASH && prev_reg == bbc_pkg::CH_SLASH)
                    begin
                        mode_next = bbc_pkg::MODE_LINEC;
                        prev_next = 8'd0;
                    end
                    else if (ch == bbc_pkg::CH_STAR && prev_reg == bbc_pkg::CH_SLASH)
                    begin
                        mode_next = bbc_pkg::MODE_BLOCKC;
                        pend_next = line_reg;
                        prev_next = 8'd0;
                    end
                    else if (ok != bbc_pkg::BR_NONE)
                    begin
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            err_next = 1'b1;
                            ev       = bbc_pkg::EV_ERROR;
                            kd       = {1'b0, ok};
                            ln       = line_reg;
                        end
                        else
                        begin
                            op.push    = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (ck != bbc_pkg::BR_NONE)
                    begin
                        if (count_reg == '0)
                        begin
                            err_next = 1'b1;
                            ev       = bbc_pkg::EV_ERROR;
                        end
                        else
                        begin
                            kd = {1'b0, cell_kind[0]};
                            ln = cell_line[0];
                            if (cell_kind[0] != ck)
                            begin
                                err_next = 1'b1;
                                ev       = bbc_pkg::EV_ERROR;
                            end
                            else
                            begin
                                ev         = bbc_pkg::EV_MATCH;
                                op.pop     = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                end
            endcase
        end

        if (op.push)
        begin
            top_kind = ok;
            top_line = line_reg;
        end
        else if (op.pop)
        begin
            top_kind = cell_kind[1];
            top_line = cell_line[1];
        end

        if (char_beat.last_char)
        begin
            kd = bbc_pkg::KIND_NONE;
            ln = '0;
            if (mode_next inside {bbc_pkg::MODE_DQ, bbc_pkg::MODE_SQ, bbc_pkg::MODE_BLOCKC})
            begin
                kd = (mode_next == bbc_pkg::MODE_DQ) ? bbc_pkg::KIND_DQ :
                     (mode_next == bbc_pkg::MODE_SQ) ? bbc_pkg::KIND_SQ :
                                                       bbc_pkg::KIND_BLOCK;
                ln = pend_next;
            end
            else if (count_next != '0)
            begin
                kd = {1'b0, top_kind};
                ln = top_line;
            end
            ev = (err_next || kd != bbc_pkg::KIND_NONE) ? bbc_pkg::EV_UNBAL
                                                        : bbc_pkg::EV_BAL;
            count_next = '0;
            mode_next  = bbc_pkg::MODE_NORMAL;
            prev_next  = 8'd0;
            line_next  = LINE_BITS'(1);
            pend_next  = '0;
            err_next   = 1'b0;
        end

        if (!take)
            op = '0;

        ln_wide = {{OUT_W_PAD{1'b0}}, ln};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            mode_reg      <= bbc_pkg::MODE_NORMAL;
            prev_reg      <= 8'd0;
            line_reg      <= LINE_BITS'(1);
            pend_reg      <= '0;
            err_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                count_reg <= count_next;
                mode_reg  <= mode_next;
                prev_reg  <= prev_next;
                line_reg  <= line_next;
                pend_reg  <= pend_next;
                err_reg   <= err_next;
            end
            if (take)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg.event_res   <= ev;
            res_reg.symbol_kind <= kd;
            res_reg.symbol_line <= ln_wide[bbc_pkg::OUT_LINE_BITS-1:0];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_reg;

endmodule

### design/bbc_stack_cell.sv
// ----------------------------------------------------------------------------
// bbc_stack_cell
// one entry of the shifting bracket stack: takes its upper neighbour on push,
// its lower neighbour on pop
// ----------------------------------------------------------------------------
module bbc_stack_cell #(
    parameter int LINE_BITS = bbc_pkg::LINE_BITS_DEF
) (
    input  logic                  clk,
    input  bbc_pkg::stack_op_t    op,
    input  logic [1:0]            up_kind,
    input  logic [LINE_BITS-1:0]  up_line,
    input  logic [1:0]            down_kind,
    input  logic [LINE_BITS-1:0]  down_line,
    output logic [1:0]            kind,
    output logic [LINE_BITS-1:0]  line
);

    logic [1:0]           kind_reg;
    logic [LINE_BITS-1:0] line_reg;

    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            kind_reg <= up_kind;
            line_reg <= up_line;
        end
        else if (op.pop)
        begin
            kind_reg <= down_kind;
            line_reg <= down_line;
        end
    end

    assign kind = kind_reg;
    assign line = line_reg;

endmodule
